[rtl/hpid_pkg.sv]
package hpid_pkg;

  // Sample and fixed-point formats
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;

  // Gains are unsigned Q8.FRAC_BITS
  localparam int GAIN_W = 8 + FRAC_BITS;
  // Signed error between two samples
  localparam int ERR_W  = SAMPLE_BITS + 1;
  // Signed product of a gain and an error
  localparam int PROD_W = GAIN_W + ERR_W;
  // Integral accumulator, signed Q16.FRAC_BITS
  localparam int ACC_W  = 32;
  // Working width for the sum of the three terms
  localparam int WORK_W = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;

  // Limit and window registers
  localparam int ELIM_W = SAMPLE_BITS;
  localparam int WIN_W  = SAMPLE_BITS;
  localparam int LIM_W  = 15;
  localparam int ILIM_W = LIM_W + FRAC_BITS;

  // Heater command width
  localparam int DRIVE_W = 16;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DRIVE_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_DATA_W = GAIN_W;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_INTEG_GAIN_STEP = 3'd1,
    CFG_DERIV_GAIN_STEP = 3'd2,
    CFG_ERROR_LIMIT     = 3'd3,
    CFG_INTEGRAL_LIMIT  = 3'd4,
    CFG_WINDOW          = 3'd5
  } cfg_idx_t;

  // Reset values: Kp 10, Ki times period 0.007, Kd over period 8
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST =
    GAIN_W'(10) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_STEP_RST =
    GAIN_W'((7 * (2 ** FRAC_BITS) + 500) / 1000);
  localparam logic [GAIN_W-1:0] DERIV_GAIN_STEP_RST =
    GAIN_W'(8) << FRAC_BITS;
  localparam logic [ELIM_W-1:0] ERROR_LIMIT_RST    = ELIM_W'(100);
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = LIM_W'(1000);
  localparam logic [WIN_W-1:0]  WINDOW_RST         = WIN_W'(40);

  // Largest positive accumulator value, in the working width
  localparam logic signed [WORK_W-1:0] ACC_MAX =
    {{(WORK_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};

  // Error terms of one sample, handed from the error stage to the core
  typedef struct packed {
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_step;
    logic                     win;
    logic [SAMPLE_BITS-1:0]   setpoint;
  } hpid_terms_t;

endpackage

[rtl/heater_pid_controller_core.sv]
// Channel | Port group  | Payload
// input   | in_t*       | tdata: measured, setpoint; tuser: run
// result  | out_t*      | tdata: heater_drive; tuser: in_window
// config  | cfg_*       | register index and write data, no read-back
//
// Each transaction goes through an input register and a result register, with combinational
// arithmetic between them, so a new sample is taken every cycle while the result side does
// not stall. The integral accumulator and the previous setpoint close their loop through
// that arithmetic. Reset is synchronous and active low and restores the default gains and
// limits. A stall on the result side holds both registers; the input side keeps accepting
// while the input register can move on.
module heater_pid_controller_core
  import hpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // measured, setpoint
  input  logic                  in_tuser,   // run

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // heater_drive
  output logic                  out_tuser,  // in_window

  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [GAIN_W-1:0]      prop_gain_r;
  logic [GAIN_W-1:0]      integ_gain_step_r;
  logic [GAIN_W-1:0]      deriv_gain_step_r;
  logic [ELIM_W-1:0]      error_limit_r;
  logic [LIM_W-1:0]       integral_limit_r;
  logic [WIN_W-1:0]       window_r;

  // Input register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_meas_r;
  logic [SAMPLE_BITS-1:0] s1_setp_r;
  logic                   s1_run_r;

  // Result register
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [DRIVE_W-1:0]     out_drive_r;
  logic                   out_win_r;

  logic                   in_accept;
  logic                   s1_adv;
  hpid_terms_t            terms;
  logic [DRIVE_W-1:0]     core_drive;

  // Configuration writes, masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r       <= PROP_GAIN_RST;
      integ_gain_step_r <= INTEG_GAIN_STEP_RST;
      deriv_gain_step_r <= DERIV_GAIN_STEP_RST;
      error_limit_r     <= ERROR_LIMIT_RST;
      integral_limit_r  <= INTEGRAL_LIMIT_RST;
      window_r          <= WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PROP_GAIN:       prop_gain_r       <= cfg_wdata[GAIN_W-1:0];
        CFG_INTEG_GAIN_STEP: integ_gain_step_r <= cfg_wdata[GAIN_W-1:0];
        CFG_DERIV_GAIN_STEP: deriv_gain_step_r <= cfg_wdata[GAIN_W-1:0];
        CFG_ERROR_LIMIT:     error_limit_r     <= cfg_wdata[ELIM_W-1:0];
        CFG_INTEGRAL_LIMIT:  integral_limit_r  <= cfg_wdata[LIM_W-1:0];
        CFG_WINDOW:          window_r          <= cfg_wdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result slot is free
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meas_r <= in_tdata[SAMPLE_BITS-1:0];
      s1_setp_r <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_run_r  <= in_tuser;
    end
  end

  // Error, proportional term and integral increment
  hpid_terms u_terms (
    .measured        (s1_meas_r),
    .setpoint        (s1_setp_r),
    .prop_gain       (prop_gain_r),
    .integ_gain_step (integ_gain_step_r),
    .error_limit     (error_limit_r),
    .window          (window_r),
    .terms           (terms)
  );

  // Integral and derivative state, sum and saturation
  hpid_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (s1_adv && s1_run_r),
    .terms           (terms),
    .deriv_gain_step (deriv_gain_step_r),
    .integral_limit  (integral_limit_r),
    .drive           (core_drive)
  );

  // Result capture; with run low the heater is off and the window flag clear
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_drive_r <= s1_run_r ? core_drive : '0;
      out_win_r   <= s1_run_r && terms.win;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_drive_r);
  assign out_tuser  = out_win_r;

endmodule

[rtl/hpid_terms.sv]
module hpid_terms
  import hpid_pkg::*;
(
  input  logic [SAMPLE_BITS-1:0] measured,
  input  logic [SAMPLE_BITS-1:0] setpoint,
  input  logic [GAIN_W-1:0]      prop_gain,
  input  logic [GAIN_W-1:0]      integ_gain_step,
  input  logic [ELIM_W-1:0]      error_limit,
  input  logic [WIN_W-1:0]       window,
  output hpid_terms_t            terms
);

  logic signed [ERR_W-1:0]      err;
  logic        [ERR_W-1:0]      abs_err;
  logic signed [ERR_W-1:0]      elim;
  logic signed [ERR_W-1:0]      err_clip;
  logic signed [GAIN_W+ERR_W:0] p_full;
  logic signed [GAIN_W+ERR_W:0] i_full;

  // Error is measured minus setpoint, which suits an NTC sensor
  assign err = $signed({1'b0, measured}) - $signed({1'b0, setpoint});
  assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  // Clip the error before it reaches the integral
  assign elim = $signed({1'b0, error_limit});

  always_comb begin
    if (err > elim) begin
      err_clip = elim;
    end else if (err < -elim) begin
      err_clip = -elim;
    end else begin
      err_clip = err;
    end
  end

  // Proportional term and integral increment, both exact in Q.FRAC_BITS
  assign p_full = $signed({1'b0, prop_gain}) * err;
  assign i_full = $signed({1'b0, integ_gain_step}) * err_clip;

  assign terms.p_term   = p_full[PROD_W-1:0];
  assign terms.i_step   = i_full[PROD_W-1:0];
  assign terms.win      = (abs_err < {1'b0, window});
  assign terms.setpoint = setpoint;

endmodule

[rtl/hpid_core.sv]
module hpid_core
  import hpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  hpid_terms_t        terms,
  input  logic [GAIN_W-1:0]  deriv_gain_step,
  input  logic [LIM_W-1:0]   integral_limit,
  output logic [DRIVE_W-1:0] drive
);

  logic signed [ACC_W-1:0]       integ_acc_r;
  logic signed [ACC_W-1:0]       integ_acc_nxt;
  logic [SAMPLE_BITS-1:0]        prev_op_r;
  logic [SAMPLE_BITS-1:0]        prev_op_nxt;

  logic signed [ERR_W-1:0]       d_diff;
  logic signed [GAIN_W+ERR_W:0]  d_full;
  logic signed [WORK_W-1:0]      d_term;
  logic signed [WORK_W-1:0]      p_term;
  logic signed [WORK_W-1:0]      integ_sum;
  logic signed [WORK_W-1:0]      ilim_raw;
  logic signed [WORK_W-1:0]      ilim;
  logic signed [WORK_W-1:0]      integ_clamped;
  logic signed [WORK_W-1:0]      sum;
  logic [WORK_W-FRAC_BITS-1:0]   sum_int;

  // Derivative acts on the change of setpoint since the last run tick
  assign d_diff = $signed({1'b0, terms.setpoint}) - $signed({1'b0, prev_op_r});
  assign d_full = $signed({1'b0, deriv_gain_step}) * d_diff;
  assign d_term = -WORK_W'($signed(d_full[PROD_W-1:0]));
  assign p_term = WORK_W'(terms.p_term);

  // Accumulate, then clamp; outside the window the clamp is zero
  assign integ_sum = WORK_W'(integ_acc_r) + WORK_W'(terms.i_step);
  assign ilim_raw  = {{(WORK_W - ILIM_W){1'b0}}, integral_limit, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (!terms.win) begin
      ilim = '0;
    end else if (ilim_raw > ACC_MAX) begin
      ilim = ACC_MAX;
    end else begin
      ilim = ilim_raw;
    end
  end

  always_comb begin
    if (integ_sum > ilim) begin
      integ_clamped = ilim;
    end else if (integ_sum < -ilim) begin
      integ_clamped = -ilim;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  // Sum of the three terms, truncated and saturated to the drive range
  assign sum     = p_term + integ_clamped + d_term;
  assign sum_int = sum[WORK_W-1:FRAC_BITS];

  always_comb begin
    if (sum <= 0) begin
      drive = '0;
    end else if (|sum_int[WORK_W-FRAC_BITS-1:DRIVE_W]) begin
      drive = '1;
    end else begin
      drive = sum_int[DRIVE_W-1:0];
    end
  end

  // Controller state moves only on a run transaction
  always_comb begin
    integ_acc_nxt = integ_acc_r;
    prev_op_nxt   = prev_op_r;
    if (step_en) begin
      integ_acc_nxt = integ_clamped[ACC_W-1:0];
      prev_op_nxt   = terms.setpoint;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r <= '0;
      prev_op_r   <= '0;
    end else begin
      integ_acc_r <= integ_acc_nxt;
      prev_op_r   <= prev_op_nxt;
    end
  end

endmodule
